// ===== sv/lzgf_pkg.sv =====
// Shared types and constants for the LZ group-flag decompressor.
// Used by the front end, the command queue, the back end and the top level.
package lzgf_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int OUT_LANES    = 8;
  localparam int LEN_W        = 9;   // copy length up to 273
  localparam int DIST_W       = 13;  // distance up to 4096
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [4:0] HDR_LEN   = 5'd16;
  localparam logic [4:0] MAGIC_END = 5'd4;
  localparam logic [4:0] SIZE_END  = 5'd8;
  localparam logic [7:0] MAGIC [4] = '{8'h59, 8'h61, 8'h7A, 8'h30};

  localparam logic [LEN_W-1:0] SHORT_BIAS = 9'd2;
  localparam logic [LEN_W-1:0] LONG_BIAS  = 9'h12;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_TRUNC     = 2'd2,
    ST_REF_EARLY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_LIT  = 2'd1,
    CMD_COPY = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    TK_IDLE   = 2'd0,
    TK_FIRST  = 2'd1,
    TK_SECOND = 2'd2
  } token_phase_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_BYTE  = 2'd1,
    BK_RDATA = 2'd2,
    BK_END   = 2'd3
  } back_state_t;

  // One classified input word: what the back end has to produce for it.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        lit;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  zeros;  // leading bytes that fall before the stream start
    logic [LEN_W-1:0]  len;    // bytes to produce, already clamped
    logic              last;
    status_t           status;
  } cmd_t;

endpackage

// ===== sv/lzgf_in_if.sv =====
// Compressed byte channel: valid/ready plus payload.
// Depends on nothing.
interface lzgf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== sv/lzgf_out_if.sv =====
// Decompressed result channel: valid/ready plus payload.
// Depends on nothing.
interface lzgf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  out_count;
  logic        out_last;
  logic [1:0]  out_status;

  modport source (output valid, output out_bytes, output out_count, output out_last,
                  output out_status, input ready);
  modport sink   (input valid, input out_bytes, input out_count, input out_last,
                  input out_status, output ready);
endinterface

// ===== sv/lzgf_front.sv =====
// Front end: header check, flag and token parsing, clamp and status per word.
// Depends on lzgf_pkg and lzgf_in_if.
module lzgf_front import lzgf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  lzgf_in_if.sink in_chan,
  output cmd_t    cmd,
  output logic    cmd_push,
  input  logic    cmd_full
);

  logic [4:0]   hdr_idx, hdr_next;
  logic [31:0]  target, target_next;
  logic [31:0]  produced, produced_next;
  logic [7:0]   flag, flag_next;
  logic [3:0]   fpos, fpos_next;
  token_phase_t tphase, tphase_next;
  logic [7:0]   tfirst, tfirst_next;
  logic [7:0]   tsecond, tsecond_next;
  status_t      err, err_next;

  logic             accept;
  logic             lit_go, copy_go, trunc, room, early, err3;
  logic [7:0]       b, c_first, c_second;
  logic [LEN_W-1:0] c_len, eff, zeros;
  logic [31:0]      avail;
  logic [DIST_W-1:0] distance, gap;
  status_t          err_take, err_ref;

  assign accept        = in_chan.valid && !cmd_full;
  assign in_chan.ready = !cmd_full;
  assign b             = in_chan.in_byte;

  always_comb begin
    hdr_next      = hdr_idx;
    target_next   = target;
    flag_next     = flag;
    fpos_next     = fpos;
    tphase_next   = tphase;
    tfirst_next   = tfirst;
    tsecond_next  = tsecond;
    lit_go        = 1'b0;
    copy_go       = 1'b0;
    c_first       = tfirst;
    c_second      = tsecond;
    c_len         = '0;
    trunc         = 1'b0;
    err_take      = err;
    if (err != ST_BAD_MAGIC) begin
      if (hdr_idx < HDR_LEN) begin
        if (hdr_idx < MAGIC_END) begin
          if (b != MAGIC[hdr_idx[1:0]] && err == ST_OK) err_take = ST_BAD_MAGIC;
        end else if (hdr_idx < SIZE_END) begin
          target_next = {target[23:0], b};
        end
        hdr_next = hdr_idx + 5'd1;
      end else if (produced >= target) begin
        // declared size reached: drop the word
      end else if (tphase == TK_IDLE && fpos[3]) begin
        flag_next = b;
        fpos_next = '0;
      end else if (tphase == TK_IDLE) begin
        if (flag[3'd7 - fpos[2:0]]) begin
          lit_go    = 1'b1;
          fpos_next = fpos + 4'd1;
        end else begin
          tfirst_next = b;
          tphase_next = TK_FIRST;
        end
      end else if (tphase == TK_FIRST) begin
        tsecond_next = b;
        if (tfirst[7:4] != 4'd0) begin
          copy_go     = 1'b1;
          c_second    = b;
          c_len       = {5'd0, tfirst[7:4]} + SHORT_BIAS;
          tphase_next = TK_IDLE;
          fpos_next   = fpos + 4'd1;
        end else begin
          tphase_next = TK_SECOND;
        end
      end else begin
        copy_go     = 1'b1;
        c_len       = {1'b0, b} + LONG_BIAS;
        tphase_next = TK_IDLE;
        fpos_next   = fpos + 4'd1;
      end
      // end of stream: close an open header or token
      if (in_chan.in_last && err_take != ST_BAD_MAGIC) begin
        if (hdr_next < HDR_LEN) begin
          trunc = 1'b1;
        end else if (tphase_next != TK_IDLE) begin
          trunc   = 1'b1;
          copy_go = 1'b1;
          c_first = tfirst_next;
          if (tphase_next == TK_FIRST) begin
            c_second = 8'd0;
            c_len    = (tfirst_next[7:4] != 4'd0) ?
                       ({5'd0, tfirst_next[7:4]} + SHORT_BIAS) : LONG_BIAS;
          end else begin
            c_second = tsecond_next;
            c_len    = LONG_BIAS;
          end
          tphase_next = TK_IDLE;
          fpos_next   = fpos_next + 4'd1;
        end
      end
    end

    // clamp the copy at the declared size and find bytes before stream start
    room  = produced < target;
    avail = target - produced;
    if (!room)                          eff = '0;
    else if (avail < {23'd0, c_len})    eff = avail[LEN_W-1:0];
    else                                eff = c_len;
    distance = {1'b0, c_first[3:0], c_second} + 13'd1;
    early = {19'd0, distance} > produced;
    gap   = distance - produced[DIST_W-1:0];
    if (!early)                         zeros = '0;
    else if (gap < {4'd0, eff})         zeros = gap[LEN_W-1:0];
    else                                zeros = eff;
    err3  = copy_go && (eff != '0) && early;

    if (lit_go)       produced_next = produced + 32'd1;
    else if (copy_go) produced_next = produced + {23'd0, eff};
    else              produced_next = produced;

    err_ref  = (err_take == ST_OK && err3) ? ST_REF_EARLY : err_take;
    err_next = (err_ref == ST_OK && trunc) ? ST_TRUNC : err_ref;

    if (lit_go)                      cmd.kind = CMD_LIT;
    else if (copy_go && eff != '0)   cmd.kind = CMD_COPY;
    else                             cmd.kind = CMD_NONE;
    cmd.lit      = b;
    cmd.distance = distance;
    cmd.zeros    = lit_go ? '0 : zeros;
    cmd.len      = lit_go ? 9'd1 : (copy_go ? eff : '0);
    cmd.last     = in_chan.in_last;
    cmd.status   = err_next;
    cmd_push     = accept && (cmd.kind != CMD_NONE || in_chan.in_last);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_chan.in_last)) begin
      hdr_idx  <= '0;
      target   <= '0;
      produced <= '0;
      flag     <= '0;
      fpos     <= 4'd8;
      tphase   <= TK_IDLE;
      tfirst   <= '0;
      tsecond  <= '0;
      err      <= ST_OK;
    end else if (accept) begin
      hdr_idx  <= hdr_next;
      target   <= target_next;
      produced <= produced_next;
      flag     <= flag_next;
      fpos     <= fpos_next;
      tphase   <= tphase_next;
      tfirst   <= tfirst_next;
      tsecond  <= tsecond_next;
      err      <= err_next;
    end
  end

`ifndef SYNTHESIS
  a_fpos_range: assert property (@(posedge clk) disable iff (rst) fpos <= 4'd8)
    else $error("flag position out of range");
  a_produced_clamp: assert property (@(posedge clk) disable iff (rst)
    hdr_idx == HDR_LEN |-> produced <= target)
    else $error("produced count past declared size");
`endif

endmodule

// ===== sv/lzgf_cmd_fifo.sv =====
// Short command queue between front and back end.
// Depends on lzgf_pkg.
module lzgf_cmd_fifo import lzgf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic full,
  output logic empty
);

  cmd_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full  = count == FIFO_DEPTH[FIFO_AW:0];
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("command queue underflow");
`endif

endmodule

// ===== sv/lzgf_back.sv =====
// Back end: history ring, byte-serial copy engine and 8-lane output packing.
// Depends on lzgf_pkg and lzgf_out_if.
module lzgf_back import lzgf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_empty,
  output logic        cmd_pop,
  lzgf_out_if.source  out_chan
);

  back_state_t      state, state_next;
  cmd_t             cur, cur_next;
  logic [LEN_W-1:0] rem, rem_next, zrem, zrem_next;
  logic [WIN_AW-1:0] wp, wp_next, rd_addr;
  logic [63:0]      pack, pack_next;
  logic [3:0]       pcnt, pcnt_next;
  logic             sent, sent_next;
  logic             out_free, emit, emit_last, we;
  logic [7:0]       wbyte, rd_data;
  logic [7:0]       ring [WINDOW_DEPTH];

  assign out_free = !out_chan.valid || out_chan.ready;
  assign rd_addr  = wp - cur.distance[WIN_AW-1:0];

  always_comb begin
    state_next = state;
    cur_next   = cur;
    rem_next   = rem;
    zrem_next  = zrem;
    wp_next    = wp;
    pack_next  = pack;
    pcnt_next  = pcnt;
    sent_next  = sent;
    cmd_pop    = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    we         = 1'b0;
    wbyte      = 8'd0;
    case (state)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          cur_next   = cmd;
          rem_next   = cmd.len;
          zrem_next  = cmd.zeros;
          sent_next  = 1'b0;
          state_next = BK_BYTE;
        end
      end
      BK_BYTE: begin
        if (rem == '0) begin
          state_next = BK_END;
        end else if (pcnt[3]) begin
          if (out_free) begin
            emit      = 1'b1;
            pack_next = '0;
            pcnt_next = '0;
            sent_next = 1'b1;
          end
        end else if (zrem != '0) begin
          we        = 1'b1;
          zrem_next = zrem - 9'd1;
          rem_next  = rem - 9'd1;
        end else if (cur.kind == CMD_LIT) begin
          we       = 1'b1;
          wbyte    = cur.lit;
          rem_next = rem - 9'd1;
        end else begin
          state_next = BK_RDATA;
        end
      end
      BK_RDATA: begin
        we         = 1'b1;
        wbyte      = rd_data;
        rem_next   = rem - 9'd1;
        state_next = BK_BYTE;
      end
      BK_END: begin
        if (pcnt != '0 || (cur.last && !sent)) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_last  = cur.last;
            pack_next  = '0;
            pcnt_next  = '0;
            state_next = BK_IDLE;
            if (cur.last) wp_next = '0;
          end
        end else begin
          state_next = BK_IDLE;
          if (cur.last) wp_next = '0;
        end
      end
      default: state_next = BK_IDLE;
    endcase
    if (we) begin
      pack_next[{pcnt[2:0], 3'b000} +: 8] = wbyte;
      pcnt_next = pcnt + 4'd1;
      wp_next   = wp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) ring[wp] <= wbyte;
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      wp    <= '0;
      pcnt  <= '0;
      pack  <= '0;
      sent  <= 1'b0;
      rem   <= '0;
      zrem  <= '0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      pcnt  <= pcnt_next;
      pack  <= pack_next;
      sent  <= sent_next;
      rem   <= rem_next;
      zrem  <= zrem_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_chan.valid <= 1'b0;
    end else if (emit) begin
      out_chan.valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_chan.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_chan.out_bytes  <= pack;
      out_chan.out_count  <= pcnt;
      out_chan.out_last   <= emit_last;
      out_chan.out_status <= cur.status;
    end
  end

`ifndef SYNTHESIS
  a_pcnt_range: assert property (@(posedge clk) disable iff (rst) pcnt <= 4'd8)
    else $error("pack count out of range");
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    emit && pcnt == 4'd0 |-> emit_last)
    else $error("empty result that does not end the stream");
`endif

endmodule

// ===== sv/lz_group_flag_decompressor.sv =====
// Top level of the LZ group-flag (Yaz0-style) stream decompressor.
// Depends on lzgf_pkg, lzgf_in_if, lzgf_out_if, lzgf_front, lzgf_cmd_fifo, lzgf_back.
//
//   channel   | dir | payload                                    | word
//   in_chan   | in  | in_byte[7:0], in_last                      | one compressed byte
//   out_chan  | out | out_bytes[63:0], out_count[3:0],           | up to 8 output bytes
//             |     | out_last, out_status[1:0]                  |
//
// Flow: the front end takes one word per cycle while the 4-entry command
// queue has room. The back end reads each copied byte from the ring, then
// writes it; literal and before-start bytes are written directly. Each command
// also passes through the idle and end states, and a result word is emitted
// whenever eight bytes are packed before the command ends.
// Reset: synchronous rst clears all control state; the 4096-byte history ring
// needs no clearing pass, since a read only reaches bytes written in the
// current stream. Stalls: out_chan.ready low holds the back end; the queue
// lets the front keep taking words meanwhile.
module lz_group_flag_decompressor import lzgf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lzgf_in_if.sink    in_chan,
  lzgf_out_if.source out_chan
);

  cmd_t front_cmd, queue_cmd;
  logic push, pop, full, empty;

  // classify compressed bytes into literal and copy commands
  lzgf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .cmd      (front_cmd),
    .cmd_push (push),
    .cmd_full (full)
  );

  // decouple parsing from the slower copy engine
  lzgf_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cmd),
    .pop   (pop),
    .dout  (queue_cmd),
    .full  (full),
    .empty (empty)
  );

  // carry out literals and copies, pack bytes into words
  lzgf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (queue_cmd),
    .cmd_empty (empty),
    .cmd_pop   (pop),
    .out_chan  (out_chan)
  );

endmodule
